>>> rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, switched off while rst is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check on clk that also runs through reset
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// shared widths, codes and the job record of the circle rasterizer
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int CX_W      = 11;
  localparam int CY_W      = 10;
  localparam int RADIUS_W  = 10;
  localparam int COLOR_W   = 32;
  localparam int ADDR_W    = 20;
  localparam int STEP_X_W  = 11;
  localparam int STEP_Y_W  = 12;
  localparam int DEC_W     = 14;
  localparam int COORD_W   = 13;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam int DEF_FRAME_WIDTH  = 1280;
  localparam int DEF_FRAME_HEIGHT = 720;
  localparam int MAX_RADIUS       = 1023;

  localparam int PIX_PER_STEP = 8;
  localparam int PIX_IDX_W    = $clog2(PIX_PER_STEP);

  localparam int JOBQ_DEPTH = 2;

  // one emitting item: centre, octant offsets, colour and end flag
  typedef struct packed {
    logic [CX_W-1:0]     cx;
    logic [CY_W-1:0]     cy;
    logic [STEP_X_W-1:0] x;
    logic [STEP_Y_W-1:0] y;
    logic [COLOR_W-1:0]  color;
    logic                done;
  } job_t;

endpackage

>>> rtl/midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// midpoint circle outline generator, eight linear pixel writes per step
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake       transfer when      payload
//   item     in         push / full     push && !full      opcode, center_x,
//                                                          center_y, radius,
//                                                          pixel_color
//   pixel    out        empty / pop     pop && !empty      pixel_address,
//                                                          write_color,
//                                                          write_enable,
//                                                          last_of_step,
//                                                          circle_done
//
// rate: an emitting item gives eight pixels, one pixel per cycle while pop keeps
//   up, through the single address pipeline of the back part; idle steps draw none
// path: the first pixel of an item passes the queue, the job register, then
//   column/row, multiply-add and the clip register
// reset: synchronous; clears the step state, the job queue and the pipeline
// stalls: a held pop freezes the pipeline; the front keeps taking items
//   until the two-entry job queue fills, then full goes high
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer import mcr_pkg::*; #(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  // item side
  input  logic                push,
  output logic                full,
  input  logic                opcode,
  input  logic [CX_W-1:0]     center_x,
  input  logic [CY_W-1:0]     center_y,
  input  logic [RADIUS_W-1:0] radius,
  input  logic [COLOR_W-1:0]  pixel_color,
  // pixel side
  output logic                empty,
  input  logic                pop,
  output logic [ADDR_W-1:0]   pixel_address,
  output logic [COLOR_W-1:0]  write_color,
  output logic                write_enable,
  output logic                last_of_step,
  output logic                circle_done
);

  // front to queue
  logic job_push;
  job_t job_wr;
  logic job_full;

  // queue to back
  logic job_valid;
  job_t job_rd;
  logic job_pop;

  // front: decodes start/step, runs the decision update, drops idle steps
  mcr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius      (radius),
    .pixel_color (pixel_color),
    .job_push    (job_push),
    .job         (job_wr),
    .job_full    (job_full)
  );

  // decoupling queue, lets the front run ahead of the pixel pipeline
  mcr_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_job   (job_wr),
    .full     (job_full),
    .rd_valid (job_valid),
    .rd_job   (job_rd),
    .rd_en    (job_pop)
  );

  // back: octant sequencer plus address/clip pipeline with output register
  mcr_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job_in        (job_rd),
    .job_pop       (job_pop),
    .empty         (empty),
    .pop           (pop),
    .pixel_address (pixel_address),
    .write_color   (write_color),
    .write_enable  (write_enable),
    .last_of_step  (last_of_step),
    .circle_done   (circle_done)
  );

endmodule

>>> rtl/mcr_front.sv
// ----------------------------------------------------------------------------
// mcr_front
// takes items, keeps the midpoint step state and hands jobs to the queue
// ----------------------------------------------------------------------------
module mcr_front import mcr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                opcode,
  input  logic [CX_W-1:0]     center_x,
  input  logic [CY_W-1:0]     center_y,
  input  logic [RADIUS_W-1:0] radius,
  input  logic [COLOR_W-1:0]  pixel_color,
  output logic                job_push,
  output job_t                job,
  input  logic                job_full
);

  logic [STEP_X_W-1:0]      step_x;
  logic signed [STEP_Y_W-1:0] step_y;
  logic signed [DEC_W-1:0]  decision;
  logic [CX_W-1:0]          held_center_x;
  logic [CY_W-1:0]          held_center_y;
  logic [COLOR_W-1:0]       held_color;
  logic                     active;

  logic                     accept;
  logic                     is_start;
  logic [RADIUS_W-1:0]      r_sat;
  logic [STEP_X_W-1:0]      x_next;
  logic signed [STEP_Y_W-1:0] y_next;
  logic signed [DEC_W-1:0]  d_next;
  logic signed [DEC_W-1:0]  xs;
  logic signed [DEC_W-1:0]  ys;
  logic                     d_pos;
  logic                     done_next;
  logic signed [STEP_Y_W-1:0] y_start;
  logic signed [DEC_W-1:0]  d_start;

  assign full     = job_full;
  assign accept   = push && !job_full;
  assign is_start = (opcode == OP_START);

  assign r_sat   = (int'(radius) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : radius;
  assign y_start = $signed(STEP_Y_W'(r_sat));
  assign d_start = 14'sd3 - ($signed(DEC_W'(r_sat)) <<< 1);

  // one midpoint step
  assign x_next = step_x + 1'b1;
  assign d_pos  = decision > 14'sd0;
  assign y_next = d_pos ? (step_y - 12'sd1) : step_y;
  assign xs     = $signed(DEC_W'(x_next));
  assign ys     = DEC_W'(y_next);
  assign d_next = d_pos ? (decision + ((xs - ys) <<< 2) + 14'sd10)
                        : (decision + (xs <<< 2) + 14'sd6);
  assign done_next = ys < xs;

  assign job_push = accept && (is_start || active);

  always_comb begin
    if (is_start) begin
      job.cx    = center_x;
      job.cy    = center_y;
      job.x     = '0;
      job.y     = y_start;
      job.color = pixel_color;
      job.done  = 1'b0;
    end else begin
      job.cx    = held_center_x;
      job.cy    = held_center_y;
      job.x     = x_next;
      job.y     = y_next;
      job.color = held_color;
      job.done  = done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x        <= '0;
      step_y        <= '0;
      decision      <= '0;
      held_center_x <= '0;
      held_center_y <= '0;
      held_color    <= '0;
      active        <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        step_x        <= '0;
        step_y        <= y_start;
        decision      <= d_start;
        held_center_x <= center_x;
        held_center_y <= center_y;
        held_color    <= pixel_color;
        active        <= 1'b1;
      end else if (active) begin
        step_x   <= x_next;
        step_y   <= y_next;
        decision <= d_next;
        active   <= !done_next;
      end
    end
  end

endmodule

>>> rtl/mcr_job_queue.sv
// ----------------------------------------------------------------------------
// mcr_job_queue
// short register queue of jobs between the front and the back
// ----------------------------------------------------------------------------
module mcr_job_queue import mcr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  output logic rd_valid,
  output job_t rd_job,
  input  logic rd_en
);

  localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

  job_t             slots [JOBQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == CNT_W'(JOBQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/mcr_back.sv
// ----------------------------------------------------------------------------
// mcr_back
// walks the eight octant pixels of a job through the address pipeline
// ----------------------------------------------------------------------------
module mcr_back import mcr_pkg::*; #(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  job_t               job_in,
  output logic               job_pop,
  output logic               empty,
  input  logic               pop,
  output logic [ADDR_W-1:0]  pixel_address,
  output logic [COLOR_W-1:0] write_color,
  output logic               write_enable,
  output logic               last_of_step,
  output logic               circle_done
);

  localparam int FW_W   = $clog2(FRAME_WIDTH + 1) + 1;
  localparam int PROD_W = COORD_W + FW_W + 1;
  localparam int LIM_W  = $clog2(FRAME_WIDTH * FRAME_HEIGHT + 1) + 1;
  localparam int SUM_W  = (PROD_W > LIM_W) ? PROD_W : LIM_W;
  localparam logic signed [SUM_W-1:0] FW_S  = SUM_W'(FRAME_WIDTH);
  localparam logic signed [SUM_W-1:0] LIM_S = SUM_W'(FRAME_WIDTH * FRAME_HEIGHT);

  // sequencer
  logic                 busy;
  job_t                 cur;
  logic [PIX_IDX_W-1:0] idx;
  logic                 adv0;
  logic                 last_idx;

  // stage 1: column and row
  logic                      v1;
  logic signed [COORD_W-1:0] col1;
  logic signed [COORD_W-1:0] row1;
  logic [COLOR_W-1:0]        color1;
  logic                      last1;
  logic                      done1;

  // stage 2: linear address
  logic                    v2;
  logic signed [SUM_W-1:0] sum2;
  logic [COLOR_W-1:0]      color2;
  logic                    last2;
  logic                    done2;

  // stage 3: result register
  logic v3;

  logic rdy1;
  logic rdy2;
  logic rdy3;

  logic signed [COORD_W-1:0] cxs;
  logic signed [COORD_W-1:0] cys;
  logic signed [COORD_W-1:0] xo;
  logic signed [COORD_W-1:0] yo;
  logic signed [COORD_W-1:0] col_off;
  logic signed [COORD_W-1:0] row_off;
  logic signed [COORD_W-1:0] col0;
  logic signed [COORD_W-1:0] row0;
  logic                      in_frame;

  assign rdy3 = !v3 || pop;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign adv0     = busy && rdy1;
  assign last_idx = (idx == PIX_IDX_W'(PIX_PER_STEP - 1));
  assign job_pop  = job_valid && (!busy || (adv0 && last_idx));

  // idx bit 2 swaps x and y, bit 0 negates the column, bit 1 the row
  assign cxs     = $signed(COORD_W'(cur.cx));
  assign cys     = $signed(COORD_W'(cur.cy));
  assign xo      = $signed(COORD_W'(cur.x));
  assign yo      = COORD_W'($signed(cur.y));
  assign col_off = idx[2] ? yo : xo;
  assign row_off = idx[2] ? xo : yo;
  assign col0    = idx[0] ? (cxs - col_off) : (cxs + col_off);
  assign row0    = idx[1] ? (cys - row_off) : (cys + row_off);

  // sign bit clear means a non-negative address
  assign in_frame = !sum2[SUM_W-1] && (sum2 < LIM_S);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (job_pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (adv0) begin
        idx <= idx + 1'b1;
        if (last_idx) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= adv0;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      col1   <= col0;
      row1   <= row0;
      color1 <= cur.color;
      last1  <= last_idx;
      done1  <= cur.done;
    end
    if (rdy2) begin
      sum2   <= SUM_W'(row1) * FW_S + SUM_W'(col1);
      color2 <= color1;
      last2  <= last1;
      done2  <= done1;
    end
    if (rdy3) begin
      pixel_address <= in_frame ? sum2[ADDR_W-1:0] : '0;
      write_enable  <= in_frame;
      write_color   <= color2;
      last_of_step  <= last2;
      circle_done   <= done2;
    end
  end

  assign empty = !v3;

endmodule

>>> rtl/mcr_checker.sv
// ----------------------------------------------------------------------------
// mcr_checker
// port-level checks on the pixel side of the circle rasterizer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcr_checker import mcr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic [ADDR_W-1:0]  pixel_address,
  input logic [COLOR_W-1:0] write_color,
  input logic               write_enable,
  input logic               last_of_step,
  input logic               circle_done
);

  // clipped pixels carry a zero address
  `ASSERT_CLK(a_clip_addr_zero, !empty && !write_enable |-> pixel_address == '0, "clipped pixel with nonzero address")

  // the eight pixels of a step come without gaps
  `ASSERT_CLK(a_step_no_gap, pop && !empty && !last_of_step |=> !empty, "gap inside a step")

  // colour and end flag do not change inside a step
  `ASSERT_CLK(a_step_uniform, pop && !empty && !last_of_step |=> write_color == $past(write_color) && circle_done == $past(circle_done), "step fields changed mid-step")

  // a waiting pixel holds
  `ASSERT_CLK(a_hold, !empty && !pop |=> !empty && $stable(pixel_address) && $stable(write_enable), "waiting pixel changed")

  // nothing shows right after reset
  `ASSERT_RST(a_reset_empty, rst |=> empty, "pixel present after reset")

endmodule

bind midpoint_circle_rasterizer mcr_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .pixel_address (pixel_address),
  .write_color   (write_color),
  .write_enable  (write_enable),
  .last_of_step  (last_of_step),
  .circle_done   (circle_done)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the midpoint circle rasterizer: circles are started
// and stepped through the item queue, every pixel transfer is compared with a
// cycle-free predictor of the octant walk, the frame clip and the end flag
// ----------------------------------------------------------------------------
module tb_top import mcr_pkg::*; ();

  localparam int FRAME_W     = DEF_FRAME_WIDTH;
  localparam int FRAME_H     = DEF_FRAME_HEIGHT;
  localparam int ITEM_GOAL   = 220;      // items sent in all, directed part included
  localparam int CYCLE_LIMIT = 400000;   // watchdog bound on the whole run
  localparam int TAIL_CYCLES = 40;       // covers the pipeline path plus receiver gaps
  localparam int HOLD_AFTER  = 400;      // pixel count at which the long hold-off starts
  localparam int HOLD_CYCLES = 300;

  // one item as offered on the push side
  typedef struct packed {
    logic                op;
    logic [CX_W-1:0]     cx;
    logic [CY_W-1:0]     cy;
    logic [RADIUS_W-1:0] r;
    logic [COLOR_W-1:0]  color;
  } circle_item_t;

  // one pixel as seen on the pop side
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               en;
    logic               last;
    logic               done;
  } pixel_t;

  // --------------------------------------------------------------------------
  // scoreboard: walks the circle itself and keeps the pixels still owed
  // --------------------------------------------------------------------------
  class pixel_scoreboard;
    int           step_x;
    int           step_y;
    int           decision;
    logic [CX_W-1:0]    held_cx;
    logic [CY_W-1:0]    held_cy;
    logic [COLOR_W-1:0] held_color;
    bit           active;
    pixel_t       pending_pixels[$];
    int           errors;
    int           checked;
    int           circles_done;
    int           idle_steps;

    function new();
      step_x       = 0;
      step_y       = 0;
      decision     = 0;
      held_cx      = '0;
      held_cy      = '0;
      held_color   = '0;
      active       = 0;
      errors       = 0;
      checked      = 0;
      circles_done = 0;
      idle_steps   = 0;
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    // linear address with signed column/row, clipped against the whole frame
    function void put_pixel(int col, int row, bit last, bit done);
      longint lin;
      pixel_t p;
      lin    = longint'(col) + longint'(row) * longint'(FRAME_W);
      p.en   = (lin >= 0) && (lin < longint'(FRAME_W) * longint'(FRAME_H));
      p.addr = p.en ? lin[ADDR_W-1:0] : '0;
      p.color = held_color;
      p.last = last;
      p.done = done;
      pending_pixels.push_back(p);
    endfunction

    // eight-way symmetry in the block's octant order
    function void emit_octants(bit done);
      int cx;
      int cy;
      cx = int'(held_cx);
      cy = int'(held_cy);
      put_pixel(cx + step_x, cy + step_y, 0, done);
      put_pixel(cx - step_x, cy + step_y, 0, done);
      put_pixel(cx + step_x, cy - step_y, 0, done);
      put_pixel(cx - step_x, cy - step_y, 0, done);
      put_pixel(cx + step_y, cy + step_x, 0, done);
      put_pixel(cx - step_y, cy + step_x, 0, done);
      put_pixel(cx + step_y, cy - step_x, 0, done);
      put_pixel(cx - step_y, cy - step_x, 1, done);
    endfunction

    // advance the circle by one accepted item, returns pixels it owes
    function int rasterize_item(circle_item_t it);
      int  r;
      bit  done;
      if (it.op == OP_START) begin
        r = int'(it.r);
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        held_cx    = it.cx;
        held_cy    = it.cy;
        held_color = it.color;
        step_x     = 0;
        step_y     = r;
        decision   = 3 - 2 * r;
        active     = 1;
        emit_octants(0);
        return PIX_PER_STEP;
      end
      if (!active) begin
        idle_steps++;
        return 0;
      end
      step_x++;
      if (decision > 0) begin
        step_y--;
        decision += 4 * (step_x - step_y) + 10;
      end else begin
        decision += 4 * step_x + 6;
      end
      done = step_y < step_x;
      if (done) begin
        active = 0;
        circles_done++;
      end
      emit_octants(done);
      return PIX_PER_STEP;
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $error("pixel transfer with nothing pending: address %0d", got.addr);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      checked++;
      compare_field("pixel_address", want.addr,  got.addr);
      compare_field("write_color",   want.color, got.color);
      compare_field("write_enable",  want.en,    got.en);
      compare_field("last_of_step",  want.last,  got.last);
      compare_field("circle_done",   want.done,  got.done);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the block
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  logic                opcode;
  logic [CX_W-1:0]     center_x;
  logic [CY_W-1:0]     center_y;
  logic [RADIUS_W-1:0] radius;
  logic [COLOR_W-1:0]  pixel_color;
  logic                empty;
  logic                pop;
  logic [ADDR_W-1:0]   pixel_address;
  logic [COLOR_W-1:0]  write_color;
  logic                write_enable;
  logic                last_of_step;
  logic                circle_done;

  pixel_scoreboard sb;
  int              cycles;
  int              items_sent;
  int              pixel_items;
  bit              send_calm;
  bit              recv_calm;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  midpoint_circle_rasterizer #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .opcode        (opcode),
    .center_x      (center_x),
    .center_y      (center_y),
    .radius        (radius),
    .pixel_color   (pixel_color),
    .empty         (empty),
    .pop           (pop),
    .pixel_address (pixel_address),
    .write_color   (write_color),
    .write_enable  (write_enable),
    .last_of_step  (last_of_step),
    .circle_done   (circle_done)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycles, sb.pending());
      $display("** midpoint_circle_rasterizer: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driving tasks
  // --------------------------------------------------------------------------

  // per-transfer wait; calm stretches run with no gaps at all
  function automatic int idle_draw(bit calm);
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic circle_item_t make_item(logic op, int cx, int cy, int r,
                                             logic [COLOR_W-1:0] color);
    circle_item_t it;
    it.op    = op;
    it.cx    = cx[CX_W-1:0];
    it.cy    = cy[CY_W-1:0];
    it.r     = r[RADIUS_W-1:0];
    it.color = color;
    return it;
  endfunction

  // called right after an edge; returns right after the edge of its transfer
  task automatic send_item(circle_item_t it);
    int gap;
    if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
    gap = idle_draw(send_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    opcode      <= it.op;
    center_x    <= it.cx;
    center_y    <= it.cy;
    radius      <= it.r;
    pixel_color <= it.color;
    // full read here is the value the block saw at this edge
    do @(posedge clk); while (full);
    items_sent++;
    if (sb.rasterize_item(it) != 0) pixel_items++;
  endtask

  // step items carry random leftovers in the unused fields
  task automatic send_step();
    send_item(make_item(OP_STEP, $urandom_range(0, 2047), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom));
  endtask

  task automatic send_start(int cx, int cy, int r, logic [COLOR_W-1:0] color);
    send_item(make_item(OP_START, cx, cy, r, color));
  endtask

  // pop side: random gaps, plus one long hold-off so the item queue fills
  task automatic receive_pixels();
    int     gap;
    int     popped;
    bit     held;
    pixel_t got;
    popped = 0;
    held   = 0;
    forever begin
      if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
      gap = idle_draw(recv_calm);
      if (!held && popped >= HOLD_AFTER) begin
        gap  = HOLD_CYCLES;
        held = 1;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got.addr  = pixel_address;
      got.color = write_color;
      got.en    = write_enable;
      got.last  = last_of_step;
      got.done  = circle_done;
      sb.check_pixel(got);
      popped++;
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  // directed corners: idle steps, radius zero, clipping at every frame edge,
  // restart of a running circle, extremes of every field, a full small circle
  task automatic run_directed();
    send_step();                                   // step before any circle
    send_start(640, 360, 0, 32'hFFFF_FFFF);        // radius zero: centre eight times
    send_step();                                   // (1,-1) and the circle ends
    send_step();                                   // idle again
    send_start(0, 0, 5, 32'h0000_0000);            // top-left corner, negative addresses
    send_step();
    send_step();
    send_start(2047, 1023, 1023, 32'hA5A5_A5A5);   // restart while running, all-ones centre and radius
    send_step();
    send_step();
    send_start(1279, 719, 1, 32'h5A5A_5A5A);       // bottom-right, ends after one step
    send_step();
    send_step();                                   // idle after done
    send_start(0, 719, 1023, 32'h0123_4567);       // huge radius from a corner
    send_step();
    send_start(640, 360, 3, 32'hDEAD_BEEF);        // radius three, run to the end
    while (sb.active) send_step();
    send_step();
  endtask

  // mostly well-formed circles with random content, the rest broken or noise
  task automatic run_random();
    int  kind;
    int  r;
    int  budget;
    int  n;
    int  cx;
    int  cy;
    while (items_sent < ITEM_GOAL) begin
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        if ($urandom_range(0, 19) == 0) r = $urandom_range(0, 1023);
        else r = $urandom_range(0, 40);
        if ($urandom_range(0, 4) == 0) begin
          cx = $urandom_range(0, 2047);
          cy = $urandom_range(0, 1023);
        end else begin
          cx = $urandom_range(0, FRAME_W - 1);
          cy = $urandom_range(0, FRAME_H - 1);
        end
        send_start(cx, cy, r, $urandom);
        // one in five circles gets a short step budget and may be cut short by the next start
        budget = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 40;
        n = 0;
        while (sb.active && n < budget && items_sent < ITEM_GOAL) begin
          send_step();
          n++;
        end
        if (!sb.active && $urandom_range(0, 3) == 0) send_step();
      end else begin
        // noise: any opcode, any field values
        send_item(make_item(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                            $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom));
      end
    end
  endtask

  initial begin
    sb          = new();
    cycles      = 0;
    items_sent  = 0;
    pixel_items = 0;
    send_calm   = 0;
    recv_calm   = 0;
    rst         = 1'b1;
    push        = 1'b0;
    pop         = 1'b0;
    opcode      = OP_STEP;
    center_x    = '0;
    center_y    = '0;
    radius      = '0;
    pixel_color = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    fork
      receive_pixels();
    join_none
    run_directed();
    run_random();
    push <= 1'b0;
    // drain what is owed, then watch for stray pixels
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d pixels never arrived", sb.pending());
      sb.errors++;
    end
    $display("covered %0d items: %0d drew pixels, %0d were steps with no circle",
             items_sent, pixel_items, sb.idle_steps);
    $display("%0d circles walked to the end, %0d pixel transfers checked, %0d mismatches",
             sb.circles_done, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("** midpoint_circle_rasterizer: PASSED **");
    end else begin
      $display("** midpoint_circle_rasterizer: FAILED **");
    end
    $finish;
  end

endmodule
